// File: src/srp_pkg.sv
// Shared definitions for the shelf rectangle packer.
// Holds default parameter values, stream widths, register indexes, mode and
// status codes, and the control struct between the sequencer and fit unit.
`default_nettype none

package srp_pkg;

  // Default sizing of the shelf table and coordinate datapath.
  localparam int MAX_SHELVES_DEF = 32;
  localparam int COORD_BITS_DEF  = 16;

  // Fixed field widths on the stream ports.
  localparam int SIZE_W       = 16;
  localparam int POS_W        = 16;
  localparam int SHELF_IDX_W  = 5;
  localparam int STATUS_W     = 2;
  localparam int TDATA_IN_W   = 32;
  localparam int TUSER_IN_W   = 1;
  localparam int TDATA_OUT_W  = 40;
  localparam int TDATA_PAD_W  = TDATA_OUT_W - (2 * POS_W + SHELF_IDX_W);
  localparam int TUSER_OUT_W  = 3;

  // Configuration port.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam int MODE_W     = 2;
  localparam int SPACING_W  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING  = 4'd1;

  // Fit modes; the unused code behaves as best fit.
  localparam logic [MODE_W-1:0] FIT_NEXT  = 2'd0;
  localparam logic [MODE_W-1:0] FIT_FIRST = 2'd1;
  localparam logic [MODE_W-1:0] FIT_BEST  = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SAT  = 2'd2;

  // Control from the sequencer to the fit unit.
  typedef struct packed {
    logic clear;       // start of a new search
    logic eval;        // read data holds a shelf entry to judge
    logic first_only;  // keep the first match instead of the least waste
  } fit_ctrl_t;

endpackage

`default_nettype wire

// File: src/shelf_rectangle_packer_core.sv
// Shelf rectangle packer: one rectangle in, one placement out.
// The shelves read per rectangle are the stored count for best fit, those up to the first
// match for first fit, and only the newest for next fit; with no stored shelf none is read.
// A stalled output holds back the result. A new rectangle is taken only after the last
// result is loaded into the output register, and one read port scans one entry per cycle.
// Reset clears the shelf count, fit_mode and spacing.
`default_nettype none

module shelf_rectangle_packer_core #(
  parameter int MAX_SHELVES = srp_pkg::MAX_SHELVES_DEF,
  parameter int COORD_BITS  = srp_pkg::COORD_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Configuration write channel.
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [srp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [srp_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Rectangle stream in.
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [srp_pkg::TDATA_IN_W-1:0]  s_tdata,   // rect_width, rect_height
  input  wire logic [srp_pkg::TUSER_IN_W-1:0]  s_tuser,   // start_layout
  // Placement stream out.
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [srp_pkg::TDATA_OUT_W-1:0] m_tdata,   // pos_x, pos_y, shelf_index, pad
  output logic      [srp_pkg::TUSER_OUT_W-1:0] m_tuser    // opened_shelf, status
);

  localparam int CB = COORD_BITS;
  localparam int DW = 3 * CB;
  localparam int IW = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
  localparam int TW = $clog2(MAX_SHELVES + 1);
  localparam int SW = ((CB > srp_pkg::SIZE_W) ? CB : srp_pkg::SIZE_W) + 1;
  localparam logic [SW-1:0] CMAX_W = {{(SW - CB){1'b0}}, {CB{1'b1}}};

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    DECIDE,
    EMIT
  } state_t;

  state_t state;

  // Registers.
  logic [srp_pkg::MODE_W-1:0]    fit_mode;
  logic [srp_pkg::SPACING_W-1:0] spacing;
  logic [TW-1:0]                 total;
  logic [TW-1:0]                 issue_cnt;
  logic                          pend;
  logic [IW-1:0]                 pend_idx;
  logic [CB-1:0]                 pw;
  logic [CB-1:0]                 ph;
  logic                          pad_sat;
  logic                          mem_we;
  logic [IW-1:0]                 mem_waddr;
  logic [DW-1:0]                 mem_wdata;
  logic [srp_pkg::TDATA_OUT_W-1:0] res_data;
  logic [srp_pkg::TUSER_OUT_W-1:0] res_user;

  // Combinational values.
  logic                          accept;
  logic [TW-1:0]                 total_eff;
  logic [SW-1:0]                 pw_sum;
  logic [SW-1:0]                 ph_sum;
  logic                          first_only;
  logic                          issue;
  logic                          scan_done;
  logic [IW-1:0]                 raddr;
  logic [DW-1:0]                 rdata;
  srp_pkg::fit_ctrl_t            fit_ctrl;
  logic                          found;
  logic [IW-1:0]                 best_idx;
  logic [DW-1:0]                 best_entry;
  logic [DW-1:0]                 last_entry;
  logic [CB-1:0]                 add_a;
  logic [CB-1:0]                 add_b;
  logic [CB:0]                   add_sum;
  logic [CB-1:0]                 add_val;
  logic                          add_sat;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == IDLE);
  assign accept    = s_tvalid && s_tready;

  // Padding adders and scan control.
  always_comb begin
    total_eff  = s_tuser[0] ? '0 : total;
    pw_sum     = SW'(s_tdata[srp_pkg::SIZE_W-1:0]) + SW'(spacing);
    ph_sum     = SW'(s_tdata[2*srp_pkg::SIZE_W-1:srp_pkg::SIZE_W]) + SW'(spacing);
    first_only = (fit_mode == srp_pkg::FIT_NEXT) || (fit_mode == srp_pkg::FIT_FIRST);
    issue      = (issue_cnt < total);
    raddr      = issue_cnt[IW-1:0];
    scan_done  = (!issue && !pend) || (first_only && found);
    fit_ctrl.clear      = accept;
    fit_ctrl.eval       = (state == SCAN) && pend;
    fit_ctrl.first_only = first_only;
  end

  // Shared saturating adder: new used width of a chosen shelf, or the top
  // of a new shelf below the newest one.
  always_comb begin
    add_a   = found ? best_entry[CB-1:0] : last_entry[3*CB-1:2*CB];
    add_b   = found ? pw : last_entry[2*CB-1:CB];
    add_sum = {1'b0, add_a} + {1'b0, add_b};
    add_sat = add_sum[CB];
    add_val = add_sat ? {CB{1'b1}} : add_sum[CB-1:0];
  end

  srp_shelf_ram #(
    .DEPTH (MAX_SHELVES),
    .AW    (IW),
    .DW    (DW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  srp_fit_unit #(
    .CB (CB),
    .IW (IW)
  ) u_fit (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (fit_ctrl),
    .ph         (ph),
    .entry      (rdata),
    .entry_idx  (pend_idx),
    .found      (found),
    .best_idx   (best_idx),
    .best_entry (best_entry),
    .last_entry (last_entry)
  );

  // Sequencer, configuration registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      fit_mode <= srp_pkg::FIT_NEXT;
      spacing  <= '0;
      total    <= '0;
      pend     <= 1'b0;
      mem_we   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // Output valid: set when the result is loaded, cleared once taken.
      if ((state == EMIT) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      // Configuration beats; indexes beyond the list are dropped.
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == srp_pkg::REG_FIT_MODE) begin
          fit_mode <= cfg_data[srp_pkg::MODE_W-1:0];
        end else if (cfg_index == srp_pkg::REG_SPACING) begin
          spacing <= cfg_data[srp_pkg::SPACING_W-1:0];
        end
      end

      case (state)
        IDLE: begin
          mem_we <= 1'b0;
          if (accept) begin
            total   <= total_eff;
            pend    <= 1'b0;
            pad_sat <= (pw_sum > CMAX_W) || (ph_sum > CMAX_W);
            pw      <= (pw_sum > CMAX_W) ? {CB{1'b1}} : pw_sum[CB-1:0];
            ph      <= (ph_sum > CMAX_W) ? {CB{1'b1}} : ph_sum[CB-1:0];
            // Next fit looks only at the newest shelf.
            if ((fit_mode == srp_pkg::FIT_NEXT) && (total_eff != '0)) begin
              issue_cnt <= total_eff - 1'b1;
            end else begin
              issue_cnt <= '0;
            end
            state <= SCAN;
          end
        end

        SCAN: begin
          mem_we <= 1'b0;
          // One read issued and one entry judged per cycle.
          if (scan_done) begin
            pend  <= 1'b0;
            state <= DECIDE;
          end else begin
            pend     <= issue;
            pend_idx <= raddr;
            if (issue) begin
              issue_cnt <= issue_cnt + 1'b1;
            end
          end
        end

        DECIDE: begin
          if (found) begin
            // Place on the chosen shelf; its height already covers the item.
            mem_we    <= 1'b1;
            mem_waddr <= best_idx;
            mem_wdata <= {best_entry[3*CB-1:CB], add_val};
            res_data  <= {{srp_pkg::TDATA_PAD_W{1'b0}},
                          srp_pkg::SHELF_IDX_W'(best_idx),
                          srp_pkg::POS_W'(best_entry[3*CB-1:2*CB]),
                          srp_pkg::POS_W'(best_entry[CB-1:0])};
            res_user  <= {(pad_sat || add_sat) ? srp_pkg::STATUS_SAT : srp_pkg::STATUS_OK,
                          1'b0};
          end else if (total >= TW'(MAX_SHELVES)) begin
            // Table full: nothing stored, all fields zero.
            mem_we   <= 1'b0;
            res_data <= '0;
            res_user <= {srp_pkg::STATUS_FULL, 1'b0};
          end else begin
            // Open a new shelf below the newest one, or at the top if none.
            mem_we    <= 1'b1;
            mem_waddr <= total[IW-1:0];
            mem_wdata <= {(total != '0) ? add_val : {CB{1'b0}}, ph, pw};
            total     <= total + 1'b1;
            res_data  <= {{srp_pkg::TDATA_PAD_W{1'b0}},
                          srp_pkg::SHELF_IDX_W'(total[IW-1:0]),
                          (total != '0) ? srp_pkg::POS_W'(add_val) : {srp_pkg::POS_W{1'b0}},
                          {srp_pkg::POS_W{1'b0}}};
            res_user  <= {(pad_sat || ((total != '0) && add_sat)) ?
                          srp_pkg::STATUS_SAT : srp_pkg::STATUS_OK, 1'b1};
          end
          state <= EMIT;
        end

        EMIT: begin
          mem_we <= 1'b0;
          // Load the output register once it is free.
          if (!m_tvalid || m_tready) begin
            m_tdata  <= res_data;
            m_tuser  <= res_user;
            state    <= IDLE;
          end
        end

        default: begin
          mem_we <= 1'b0;
          state  <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/srp_shelf_ram.sv
// Shelf table memory: one write port and one registered read port.
// Each word holds a shelf's top, height and used width. Uses no package items.
`default_nettype none

module srp_shelf_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int DW    = 48
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/srp_fit_unit.sv
// Shared compare and subtract unit that judges one shelf entry per cycle.
// Tracks the chosen shelf and the last entry seen. Depends on srp_pkg.
`default_nettype none

module srp_fit_unit #(
  parameter int CB = 16,
  parameter int IW = 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire srp_pkg::fit_ctrl_t ctrl,
  input  wire logic [CB-1:0]     ph,
  input  wire logic [3*CB-1:0]   entry,
  input  wire logic [IW-1:0]     entry_idx,
  output logic                   found,
  output logic      [IW-1:0]     best_idx,
  output logic      [3*CB-1:0]   best_entry,
  output logic      [3*CB-1:0]   last_entry
);

  logic [CB-1:0] tall;
  logic [CB-1:0] waste;
  logic [CB-1:0] best;
  logic          fits;
  logic          take;

  // One compare against the shelf height and one subtract for the waste.
  always_comb begin
    tall  = entry[2*CB-1:CB];
    fits  = (ph <= tall);
    waste = tall - ph;
    take  = ctrl.eval && fits && (!found || (!ctrl.first_only && (waste < best)));
  end

  // Running choice; ties keep the earlier shelf.
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctrl.clear) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
    if (take) begin
      best       <= waste;
      best_idx   <= entry_idx;
      best_entry <= entry;
    end
    if (ctrl.eval) begin
      last_entry <= entry;
    end
  end

endmodule

`default_nettype wire

// File: src/srp_checker.sv
// Port-level checks for the shelf rectangle packer, bound to its top level.
// Depends on srp_pkg for widths and status codes.
`default_nettype none

module srp_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            cfg_valid,
  input wire logic                            cfg_ready,
  input wire logic [srp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input wire logic [srp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input wire logic                            s_tvalid,
  input wire logic                            s_tready,
  input wire logic [srp_pkg::TDATA_IN_W-1:0]  s_tdata,
  input wire logic [srp_pkg::TUSER_IN_W-1:0]  s_tuser,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [srp_pkg::TDATA_OUT_W-1:0] m_tdata,
  input wire logic [srp_pkg::TUSER_OUT_W-1:0] m_tuser
);

  // A rectangle is worked on alone: no beat is taken in the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a rectangle is in progress");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("output beat changed while stalled");

  // Status only carries one of the defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tuser[2:1] == srp_pkg::STATUS_OK) ||
                  (m_tuser[2:1] == srp_pkg::STATUS_FULL) ||
                  (m_tuser[2:1] == srp_pkg::STATUS_SAT)))
    else $error("invalid status code");

  // A full-table result carries no placement.
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser[2:1] == srp_pkg::STATUS_FULL)) |->
      ((m_tdata == '0) && !m_tuser[0]))
    else $error("full-table result carries placement data");

  // A new shelf always starts at the left edge.
  a_open_left: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[srp_pkg::POS_W-1:0] == '0))
    else $error("new shelf placement not at the left edge");

endmodule

bind shelf_rectangle_packer_core srp_checker u_srp_checker (.*);

`default_nettype wire

// File: tb/srp_placement_checker.sv
// Placement checker for the shelf rectangle packer testbench.
// Watches the config, rectangle and placement channels, keeps its own shelf
// table, and compares every placement beat against the predicted one (uses srp_pkg).
`timescale 1ns / 100ps

module srp_placement_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [srp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [srp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [srp_pkg::TDATA_IN_W-1:0]  s_tdata,   // rect_width, rect_height
  input  logic [srp_pkg::TUSER_IN_W-1:0]  s_tuser,   // start_layout
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [srp_pkg::TDATA_OUT_W-1:0] m_tdata,   // pos_x, pos_y, shelf_index, pad
  input  logic [srp_pkg::TUSER_OUT_W-1:0] m_tuser,   // opened_shelf, status
  output int                              fail_count,
  output int                              pending
);

  localparam int SHELF_SLOTS = srp_pkg::MAX_SHELVES_DEF;
  localparam int PW_         = srp_pkg::POS_W;

  typedef struct packed {
    logic [srp_pkg::POS_W-1:0]       pos_x;
    logic [srp_pkg::POS_W-1:0]       pos_y;
    logic [srp_pkg::SHELF_IDX_W-1:0] shelf_index;
    logic                            opened;
    logic [srp_pkg::STATUS_W-1:0]    status;
  } placement_t;

  // Predicted placements, oldest first.
  placement_t placement_q[$];

  // Shadow copy of the shelf table and the registers.
  logic [PW_-1:0]                shelf_top  [SHELF_SLOTS];
  logic [PW_-1:0]                shelf_tall [SHELF_SLOTS];
  logic [PW_-1:0]                shelf_fill [SHELF_SLOTS];
  int                            shelf_count;
  logic [srp_pkg::MODE_W-1:0]    mode_q;
  logic [srp_pkg::SPACING_W-1:0] spacing_q;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Saturating add; the top bit flags that the sum was clipped.
  function automatic logic [PW_:0] sat_sum(input logic [PW_-1:0] a,
                                           input logic [PW_-1:0] b);
    logic [PW_:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[PW_]) s = {1'b1, {PW_{1'b1}}};
    return s;
  endfunction

  // Place one rectangle on the shadow table and work out its placement.
  task automatic place_rect(input logic start, input logic [srp_pkg::SIZE_W-1:0] w,
                            input logic [srp_pkg::SIZE_W-1:0] h, output placement_t r);
    logic [PW_:0]   s;
    logic [PW_-1:0] pw;
    logic [PW_-1:0] ph;
    logic [PW_-1:0] waste;
    logic [PW_-1:0] best;
    logic           sat;
    logic           found;
    int             idx;
    r = '0;
    if (start) shelf_count = 0;
    sat = 1'b0;
    s = sat_sum(w, PW_'(spacing_q));
    pw = s[PW_-1:0];
    sat |= s[PW_];
    s = sat_sum(h, PW_'(spacing_q));
    ph = s[PW_-1:0];
    sat |= s[PW_];
    found = 1'b0;
    idx   = 0;
    best  = '0;

    // Shelf choice; the unused mode code falls through to best fit.
    if (mode_q == srp_pkg::FIT_NEXT) begin
      if (shelf_count > 0 && ph <= shelf_tall[shelf_count-1]) begin
        idx   = shelf_count - 1;
        found = 1'b1;
      end
    end else if (mode_q == srp_pkg::FIT_FIRST) begin
      for (int i = 0; i < shelf_count && !found; i++) begin
        if (ph <= shelf_tall[i]) begin
          idx   = i;
          found = 1'b1;
        end
      end
    end else begin
      for (int i = 0; i < shelf_count; i++) begin
        if (ph <= shelf_tall[i]) begin
          waste = shelf_tall[i] - ph;
          if (!found || waste < best) begin
            best  = waste;
            idx   = i;
            found = 1'b1;
          end
        end
      end
    end

    if (found) begin
      r.pos_x = shelf_fill[idx];
      r.pos_y = shelf_top[idx];
      s = sat_sum(shelf_fill[idx], pw);
      shelf_fill[idx] = s[PW_-1:0];
      sat |= s[PW_];
      r.shelf_index = idx[srp_pkg::SHELF_IDX_W-1:0];
      r.status = sat ? srp_pkg::STATUS_SAT : srp_pkg::STATUS_OK;
    end else if (shelf_count >= SHELF_SLOTS) begin
      // No room for another shelf: nothing is stored.
      r.status = srp_pkg::STATUS_FULL;
    end else begin
      // New shelf goes below the newest one.
      if (shelf_count > 0) begin
        s = sat_sum(shelf_top[shelf_count-1], shelf_tall[shelf_count-1]);
        r.pos_y = s[PW_-1:0];
        sat |= s[PW_];
      end
      idx = shelf_count;
      shelf_top[idx]  = r.pos_y;
      shelf_tall[idx] = ph;
      shelf_fill[idx] = pw;
      shelf_count++;
      r.shelf_index = idx[srp_pkg::SHELF_IDX_W-1:0];
      r.opened = 1'b1;
      r.status = sat ? srp_pkg::STATUS_SAT : srp_pkg::STATUS_OK;
    end
  endtask

  task automatic report_mismatch(input string what, input longint unsigned expv,
                                 input longint unsigned gotv);
    $display("ERROR at %0t: %s expected 0x%0h got 0x%0h", $time, what, expv, gotv);
    fail_count++;
  endtask

  // Sample every channel at the clock edge.
  always @(posedge clk) begin
    placement_t exp_p;
    placement_t got_p;
    if (rst) begin
      placement_q.delete();
      shelf_count = 0;
      mode_q      = srp_pkg::FIT_NEXT;
      spacing_q   = '0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          srp_pkg::REG_FIT_MODE: mode_q = cfg_data[srp_pkg::MODE_W-1:0];
          srp_pkg::REG_SPACING:  spacing_q = cfg_data[srp_pkg::SPACING_W-1:0];
          default: ;
        endcase
      end

      // Placement beat against the oldest prediction.
      if (m_tvalid && m_tready) begin
        got_p.pos_x       = m_tdata[PW_-1:0];
        got_p.pos_y       = m_tdata[2*PW_-1:PW_];
        got_p.shelf_index = m_tdata[2*PW_+srp_pkg::SHELF_IDX_W-1:2*PW_];
        got_p.opened      = m_tuser[0];
        got_p.status      = m_tuser[srp_pkg::STATUS_W:1];
        if (placement_q.size() == 0) begin
          report_mismatch("placement beat with none expected", 0, 64'(got_p));
        end else begin
          exp_p = placement_q.pop_front();
          if (got_p.pos_x != exp_p.pos_x)
            report_mismatch("pos_x", exp_p.pos_x, got_p.pos_x);
          if (got_p.pos_y != exp_p.pos_y)
            report_mismatch("pos_y", exp_p.pos_y, got_p.pos_y);
          if (got_p.shelf_index != exp_p.shelf_index)
            report_mismatch("shelf_index", exp_p.shelf_index, got_p.shelf_index);
          if (got_p.opened != exp_p.opened)
            report_mismatch("opened_shelf", exp_p.opened, got_p.opened);
          if (got_p.status != exp_p.status)
            report_mismatch("status", exp_p.status, got_p.status);
        end
      end

      // Rectangle beat: predict its placement.
      if (s_tvalid && s_tready) begin
        place_rect(s_tuser[0], s_tdata[srp_pkg::SIZE_W-1:0],
                   s_tdata[2*srp_pkg::SIZE_W-1:srp_pkg::SIZE_W], exp_p);
        placement_q.insert(placement_q.size(), exp_p);
      end
      pending <= placement_q.size();
    end
  end

endmodule

// File: tb/tb_shelf_rectangle_packer_core.sv
// Testbench top for the shelf rectangle packer core.
// Drives directed and random rectangle layouts with bursty input and a stalling
// output, and takes the verdict from srp_placement_checker (uses srp_pkg).
`timescale 1ns / 100ps

module tb_shelf_rectangle_packer_core;

  localparam int RAND_ITEMS   = 1400;
  localparam int PHASES       = 14;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int SZ_W         = srp_pkg::SIZE_W;
  // The spare mode code, which must act as best fit.
  localparam logic [srp_pkg::MODE_W-1:0] FIT_SPARE = 2'd3;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [srp_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [srp_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [srp_pkg::TDATA_IN_W-1:0]  s_tdata = '0;
  logic [srp_pkg::TUSER_IN_W-1:0]  s_tuser = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [srp_pkg::TDATA_OUT_W-1:0] m_tdata;
  logic [srp_pkg::TUSER_OUT_W-1:0] m_tuser;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int burst_left = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int rx_left = 0;
  int rx_style = 0;

  shelf_rectangle_packer_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  srp_placement_checker i_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: long hold-off on request, otherwise a changing stall pattern.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_style = $urandom_range(0, 3);
        rx_left  = $urandom_range(20, 200);
      end
      rx_left = rx_left - 1;
      case (rx_style)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= (rx_left % 7) > 2;
      endcase
    end
  end

  // Mostly small sizes, some medium, a few full range or near the top.
  function automatic logic [SZ_W-1:0] rand_size();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick <= 5) return SZ_W'($urandom_range(0, 255));
    if (pick <= 7) return SZ_W'($urandom_range(0, 4095));
    if (pick == 8) return SZ_W'($urandom_range(0, 65535));
    return SZ_W'(32'hFFFF - $urandom_range(0, 300));
  endfunction

  // One rectangle beat; the sender idles between bursts of random length.
  task automatic send_rect(input logic start, input logic [SZ_W-1:0] w,
                           input logic [SZ_W-1:0] h);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 20);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {h, w};
    s_tuser  <= start;
    do @(posedge clk); while (!s_tready);
    burst_left = burst_left - 1;
  endtask

  // Stop sending and let every placement come back before going on.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back; valid stays high across the two beats.
  task automatic set_config(input logic [srp_pkg::MODE_W-1:0] mode,
                            input logic [srp_pkg::SPACING_W-1:0] spc);
    cfg_valid <= 1'b1;
    cfg_index <= srp_pkg::REG_FIT_MODE;
    cfg_data  <= srp_pkg::CFG_DATA_W'(mode);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= srp_pkg::REG_SPACING;
    cfg_data  <= spc;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // A run of rectangles, mostly sorted by falling height as a caller would.
  task automatic send_layout(input int len, input logic fresh);
    int order;
    int step;
    int hv;
    logic [SZ_W-1:0] h;
    order = $urandom_range(0, 9);
    step  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4000) : $urandom_range(0, 40);
    hv    = int'(rand_size());
    for (int k = 0; k < len; k++) begin
      if (order <= 5) begin
        h  = SZ_W'(hv);
        hv = hv - int'($urandom_range(0, step));
        if (hv < 0) hv = 0;
      end else if (order <= 7) begin
        // Rising heights keep opening shelves until the table is full.
        h  = SZ_W'(hv);
        hv = hv + int'($urandom_range(1, step + 1));
        if (hv > 65535) hv = 65535;
      end else begin
        h = rand_size();
      end
      send_rect(fresh && k == 0, rand_size(), h);
    end
  endtask

  initial begin
    int phase_items;
    int len;
    logic [srp_pkg::MODE_W-1:0] mode;
    logic [srp_pkg::SPACING_W-1:0] spc;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Next fit: empty start, zero sizes, width and top saturation.
    set_config(srp_pkg::FIT_NEXT, 8'd0);
    send_rect(1'b1, 16'd0, 16'd0);
    send_rect(1'b0, 16'd10, 16'd0);
    send_rect(1'b0, 16'd5, 16'd20);
    send_rect(1'b0, 16'hFFFF, 16'd10);
    send_rect(1'b0, 16'd1, 16'hFFFF);
    send_rect(1'b0, 16'd0, 16'hFFFF);
    send_rect(1'b1, 16'd3, 16'd40000);
    send_rect(1'b0, 16'd3, 16'd50000);
    send_rect(1'b0, 16'd3, 16'd60000);

    // Largest spacing pushes the padded sizes past the top.
    wait_idle();
    set_config(srp_pkg::FIT_NEXT, 8'hFF);
    send_rect(1'b1, 16'hFFFF, 16'hFFFF);
    send_rect(1'b0, 16'd100, 16'd7);

    // First fit opens shelves of height 30 and 50; heights 40 and 35 go on the second.
    wait_idle();
    set_config(srp_pkg::FIT_FIRST, 8'd0);
    send_rect(1'b1, 16'd4, 16'd30);
    send_rect(1'b0, 16'd4, 16'd50);
    send_rect(1'b0, 16'd4, 16'd40);
    send_rect(1'b0, 16'd4, 16'd35);

    // Same table, mode changed mid layout.
    wait_idle();
    set_config(srp_pkg::FIT_BEST, 8'd0);
    send_rect(1'b0, 16'd4, 16'd35);
    send_rect(1'b0, 16'd4, 16'd40);
    send_rect(1'b0, 16'd4, 16'd60);

    wait_idle();
    set_config(FIT_SPARE, 8'd0);
    send_rect(1'b0, 16'd4, 16'd30);
    send_rect(1'b0, 16'd4, 16'd45);

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: begin mode = srp_pkg::FIT_NEXT;  spc = 8'd0;  end
        1: begin mode = srp_pkg::FIT_BEST;  spc = 8'hFF; end
        2: begin
          mode = FIT_SPARE;
          spc  = srp_pkg::SPACING_W'($urandom_range(0, 255));
        end
        3: begin mode = srp_pkg::FIT_FIRST; spc = 8'd0;  end
        default: begin
          mode = srp_pkg::MODE_W'($urandom_range(0, 3));
          case ($urandom_range(0, 3))
            0: spc = 8'd0;
            1: spc = 8'hFF;
            default: spc = srp_pkg::SPACING_W'($urandom_range(0, 255));
          endcase
        end
      endcase
      set_config(mode, spc);
      // Hold the output off while input keeps coming.
      if (phase == 3 || phase == 9) hold_req = hold_req + 1;
      phase_items = 0;
      while (phase_items < RAND_ITEMS / PHASES) begin
        if ($urandom_range(0, 3) != 0) begin
          len = $urandom_range(1, 40);
          send_layout(len, $urandom_range(0, 9) != 0);
          phase_items += len;
        end else begin
          send_rect(1'($urandom_range(0, 1)), SZ_W'($urandom), SZ_W'($urandom));
          phase_items++;
        end
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
